// ===== sv/rsps_pkg.sv =====
// Shared types and constants for the rotary shortest-path stepper.
`default_nettype none

package rsps_pkg;

  localparam int unsigned RevW = 16;   // revolution, stop and position field width
  localparam int unsigned RunW = 10;   // step count of one run
  localparam int unsigned HpW  = 16;   // pulse half period and tick timer

  localparam logic [RevW-1:0] RevReset     = 16'd3200;
  localparam logic [RevW-1:0] RevMin       = 16'd2;
  localparam logic [HpW-1:0]  HalfPerReset = 16'd500;
  localparam logic [RunW-1:0] RunCapReset  = 10'd1000;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEPS_PER_REV  = 3'd0,
    CFG_STOP_ZERO_POS  = 3'd1,
    CFG_STOP_ONE_POS   = 3'd2,
    CFG_STOP_TWO_POS   = 3'd3,
    CFG_STOP_THREE_POS = 3'd4,
    CFG_HALF_PERIOD    = 3'd5,
    CFG_MAX_RUN_STEPS  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_MOVE = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [1:0] stop_select;
  } in_item_t;

  typedef struct packed {
    logic            step_level;
    logic            dir_level;
    logic            busy_res;
    logic            at_target;
    logic [RevW-1:0] position;
  } out_item_t;

  // serial remainder unit handshake
  typedef struct packed {
    logic            start;
    logic [RevW-1:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [RevW-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

// ===== sv/rsps_mod.sv =====
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
`default_nettype none

module rsps_mod import rsps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mod_req_t        req_i,
  input  logic [RevW-1:0] divisor_i,
  output mod_rsp_t        rsp_o
);

  localparam int unsigned CntW = $clog2(RevW);
  localparam logic [CntW-1:0] LastCnt = CntW'(RevW - 1);

  logic            active_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [RevW-1:0] shreg_q;
  logic [RevW-1:0] rem_q;

  logic [RevW:0]   trial;
  logic [RevW:0]   div_ext;
  logic [RevW-1:0] rem_d;

  // restoring step: shift in the next dividend bit, subtract when it fits
  assign trial   = {rem_q, shreg_q[RevW-1]};
  assign div_ext = {1'b0, divisor_i};
  assign rem_d   = (trial >= div_ext) ? RevW'(trial - div_ext) : trial[RevW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      shreg_q  <= '0;
      rem_q    <= '0;
    end else if (req_i.start) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      shreg_q  <= req_i.dividend;
      rem_q    <= '0;
    end else if (active_q) begin
      rem_q   <= rem_d;
      shreg_q <= shreg_q << 1;
      cnt_q   <= cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== sv/rotary_shortest_path_stepper_unit.sv =====
// Top level of the rotary shortest-path stepper positioner.
//
// Input channel (in_valid_i/in_ready_o/in_item_i): each beat is either a
// tick (one unit of time) or a move request naming one of four stops.
// Output channel (out_valid_o/out_ready_i/out_item_o): exactly one result
// beat per input beat, in order: step and direction levels, busy, at-target
// and the drum position.
// The state update and the result are formed in the cycle of acceptance;
// the result is registered in the output register, or in the skid register
// under stall. Throughput is one beat per cycle outside a renormalize pass;
// a two-entry output stage (output register plus skid register) keeps
// in_ready_o free of out_ready_i, so one more beat is taken while a result
// waits, then input stalls until drained. Stop and drum positions are kept
// reduced modulo the revolution. A write to steps_per_rev or to a stop
// position starts a renormalize pass through a bit-serial remainder unit,
// five operands in turn, with in_ready_o low throughout. A new such write
// during the pass restarts it. Reset (rst_ni low, asynchronous) loads the
// register defaults, parks the drum at zero with no run pending and empties
// the output stage; no pass is needed after reset.
`default_nettype none

module rotary_shortest_path_stepper_unit import rsps_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RevW-1:0]    cfg_data_i,
  // item input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);

  localparam int unsigned PosW    = POSITION_BITS;
  localparam int unsigned NormOps = 5;   // drum position plus four stops
  localparam int unsigned OpW     = $clog2(NormOps);
  localparam logic [OpW-1:0] LastOp = OpW'(NormOps - 1);

  // ---------------------------------------------------------------------
  // configuration (stored already clamped where the behavior clamps)
  // ---------------------------------------------------------------------
  logic [RevW-1:0] rev_eff_q;
  logic [RevW-1:0] stop_raw_q [4];
  logic [HpW-1:0]  hp_eff_q;
  logic [RunW-1:0] max_run_q;
  logic            renorm_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_eff_q  <= RevReset;
      stop_raw_q <= '{default: '0};
      hp_eff_q   <= HalfPerReset;
      max_run_q  <= RunCapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STEPS_PER_REV:  rev_eff_q <= (cfg_data_i < RevMin) ? RevMin : cfg_data_i;
        CFG_STOP_ZERO_POS:  stop_raw_q[0] <= cfg_data_i;
        CFG_STOP_ONE_POS:   stop_raw_q[1] <= cfg_data_i;
        CFG_STOP_TWO_POS:   stop_raw_q[2] <= cfg_data_i;
        CFG_STOP_THREE_POS: stop_raw_q[3] <= cfg_data_i;
        CFG_HALF_PERIOD:    hp_eff_q <= (cfg_data_i == '0) ? HpW'(1) : cfg_data_i;
        CFG_MAX_RUN_STEPS:  max_run_q <= cfg_data_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  // any write that moves the revolution or a stop forces a renormalize pass
  always_comb begin
    renorm_req = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STEPS_PER_REV, CFG_STOP_ZERO_POS, CFG_STOP_ONE_POS,
        CFG_STOP_TWO_POS, CFG_STOP_THREE_POS: renorm_req = 1'b1;
        default: renorm_req = 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // machine state
  // ---------------------------------------------------------------------
  logic [PosW-1:0] pos_raw_q;       // drum position as reported
  logic [RevW-1:0] pos_norm_q;      // same, reduced modulo the revolution
  logic [RevW-1:0] stop_norm_q [4]; // stops reduced modulo the revolution
  logic [RunW-1:0] steps_left_q;
  logic [HpW-1:0]  timer_q;
  logic            phase_q;
  logic            dir_q;
  logic [1:0]      chosen_q;

  // ---------------------------------------------------------------------
  // renormalize sequencer
  // ---------------------------------------------------------------------
  logic           norm_busy_q;
  logic           launch_q;
  logic [OpW-1:0] op_idx_q;
  mod_req_t       mod_req;
  mod_rsp_t       mod_rsp;
  logic           nrm_store;

  assign nrm_store = norm_busy_q && !launch_q && mod_rsp.done && !renorm_req;

  always_comb begin
    mod_req.start    = launch_q && !renorm_req;
    mod_req.dividend = (op_idx_q == '0) ? RevW'(pos_raw_q)
                                        : stop_raw_q[2'(op_idx_q - 1'b1)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_busy_q <= 1'b0;
      launch_q    <= 1'b0;
      op_idx_q    <= '0;
    end else if (renorm_req) begin
      norm_busy_q <= 1'b1;
      launch_q    <= 1'b1;
      op_idx_q    <= '0;
    end else if (launch_q) begin
      launch_q <= 1'b0;
    end else if (nrm_store) begin
      if (op_idx_q == LastOp) begin
        norm_busy_q <= 1'b0;
      end else begin
        op_idx_q <= op_idx_q + 1'b1;
        launch_q <= 1'b1;
      end
    end
  end

  rsps_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mod_req),
    .divisor_i (rev_eff_q),
    .rsp_o     (mod_rsp)
  );

  // ---------------------------------------------------------------------
  // handshake and output stage
  // ---------------------------------------------------------------------
  logic      out_vld_q, skid_vld_q;
  out_item_t out_q, skid_q;
  logic      push, pop;
  out_item_t res;

  assign in_ready_o = !skid_vld_q && !norm_busy_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_vld_q && out_ready_i;

  // ---------------------------------------------------------------------
  // item datapath
  // ---------------------------------------------------------------------
  logic [RevW-1:0] half_rev;
  logic [RevW-1:0] sel_stop;
  logic            fwd, far;
  logic [RevW-1:0] diff, span;
  logic [RunW-1:0] capped;
  logic [HpW-1:0]  timer_inc;
  logic [RevW:0]   pos_inc;
  logic [RevW-1:0] pos_up, pos_dn, pos_step;
  logic [RunW-1:0] steps_dec;
  logic [3:0]      hit;

  logic [PosW-1:0] nx_pos_raw;
  logic [RevW-1:0] nx_pos_norm;
  logic [RunW-1:0] nx_steps;
  logic [HpW-1:0]  nx_timer;
  logic            nx_phase, nx_dir;
  logic [1:0]      nx_chosen;

  // shortest way: compare, take the magnitude, go around if past half a turn
  assign half_rev = rev_eff_q >> 1;
  assign sel_stop = stop_norm_q[in_item_i.stop_select];
  assign fwd      = sel_stop >= pos_norm_q;
  assign diff     = fwd ? (sel_stop - pos_norm_q) : (pos_norm_q - sel_stop);
  assign far      = diff > half_rev;
  assign span     = far ? (rev_eff_q - diff) : diff;
  assign capped   = (span > RevW'(max_run_q)) ? max_run_q : span[RunW-1:0];

  // one step up or down, wrapping at the revolution
  assign timer_inc = timer_q + 1'b1;
  assign pos_inc   = {1'b0, pos_norm_q} + 1'b1;
  assign pos_up    = (pos_inc >= {1'b0, rev_eff_q}) ? '0 : pos_inc[RevW-1:0];
  assign pos_dn    = (pos_norm_q == '0) ? (rev_eff_q - 1'b1) : (pos_norm_q - 1'b1);
  assign pos_step  = dir_q ? pos_up : pos_dn;
  assign steps_dec = steps_left_q - 1'b1;

  always_comb begin
    nx_pos_raw  = pos_raw_q;
    nx_pos_norm = pos_norm_q;
    nx_steps    = steps_left_q;
    nx_timer    = timer_q;
    nx_phase    = phase_q;
    nx_dir      = dir_q;
    nx_chosen   = chosen_q;
    if (in_item_i.mode == MODE_MOVE) begin
      // request during a run is dropped
      if (steps_left_q == '0) begin
        nx_chosen = in_item_i.stop_select;
        if (diff != '0) begin
          nx_dir   = fwd ^ far;
          nx_steps = capped;
          nx_timer = '0;
          nx_phase = (capped != '0);
        end
      end
    end else if (steps_left_q != '0) begin
      if (timer_inc < hp_eff_q) begin
        nx_timer = timer_inc;
      end else begin
        nx_timer = '0;
        if (phase_q) begin
          nx_phase = 1'b0;
        end else begin
          // end of low half: move one step
          nx_pos_raw  = PosW'(pos_step);
          nx_pos_norm = RevW'(PosW'(pos_step));
          nx_steps    = steps_dec;
          nx_phase    = (steps_dec != '0);
        end
      end
    end
  end

  // per-stop match lanes, then pick the chosen one
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hit[k] = (nx_pos_norm == stop_norm_q[k]);
    end
  end

  always_comb begin
    res.step_level = nx_phase;
    res.dir_level  = nx_dir;
    res.busy_res   = (nx_steps != '0);
    res.at_target  = hit[nx_chosen];
    res.position   = RevW'(nx_pos_raw);
  end

  // ---------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_raw_q    <= '0;
      pos_norm_q   <= '0;
      steps_left_q <= '0;
      timer_q      <= '0;
      phase_q      <= 1'b0;
      dir_q        <= 1'b0;
      chosen_q     <= '0;
    end else if (push) begin
      pos_raw_q    <= nx_pos_raw;
      pos_norm_q   <= nx_pos_norm;
      steps_left_q <= nx_steps;
      timer_q      <= nx_timer;
      phase_q      <= nx_phase;
      dir_q        <= nx_dir;
      chosen_q     <= nx_chosen;
    end else if (nrm_store && op_idx_q == '0) begin
      pos_norm_q <= mod_rsp.rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_norm_q <= '{default: '0};
    end else if (nrm_store && op_idx_q != '0) begin
      stop_norm_q[2'(op_idx_q - 1'b1)] <= mod_rsp.rem;
    end
  end

  // ---------------------------------------------------------------------
  // output register plus skid
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !out_ready_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a beat while the output register is empty");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && out_vld_q && !out_ready_i |=> skid_vld_q)
    else $error("beat accepted under stall did not land in the skid register");

  a_phase_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> steps_left_q != '0)
    else $error("step output high with no steps left");

  a_pos_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !norm_busy_q |-> pos_norm_q < rev_eff_q)
    else $error("reduced drum position not below the revolution");

  a_no_accept_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(norm_busy_q) |-> !push)
    else $error("beat accepted while a renormalize pass runs");

endmodule

`default_nettype wire
